FILE: hdl/twrt_pkg.sv
// ----------------------------------------------------------------------------
// twrt_pkg: timing wheel types and codes
// Action and status codes, and the control word passed along the cell chain.
// ----------------------------------------------------------------------------
package twrt_pkg;

  localparam logic [1:0] ACT_ADD     = 2'd0;
  localparam logic [1:0] ACT_REFRESH = 2'd1;
  localparam logic [1:0] ACT_CANCEL  = 2'd2;
  localparam logic [1:0] ACT_TICK    = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_FIRED    = 3'd3;
  localparam logic [2:0] ST_CANCELED = 3'd4;

  localparam int ID_W    = 32;
  localparam int DELAY_W = 16;

  // Command word travelling down the chain, one cell per cycle.
  typedef struct packed {
    logic              vld;
    logic [1:0]        act;
    logic [ID_W-1:0]   id;
    logic [DELAY_W-1:0] delay;
    logic              hit;      // an earlier cell matched the id
    logic              freed;    // an earlier cell took a new add
    logic              is_first; // set on the lookup pass, clear on the claim pass
  } twrt_cmd_t;

  // Release report leaving a cell.
  typedef struct packed {
    logic            rel;
    logic            canceled;
    logic [ID_W-1:0] id;
  } twrt_rel_t;

endpackage

FILE: hdl/twrt_cell.sv
// ----------------------------------------------------------------------------
// twrt_cell: one timer entry of the chain
// Holds key, canceled flag, delay slot offset and slot mask; acts on the
// command passing through and hands it, registered, to the next cell.
// ----------------------------------------------------------------------------
module twrt_cell
  import twrt_pkg::*;
#(
  parameter int WHEEL_SLOTS = 60,
  parameter int SLOT_W      = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [SLOT_W-1:0]  cur_slot,   // slot after advance for a tick
  input  twrt_cmd_t          cmd_in,
  input  logic [SLOT_W-1:0]  add_slot,   // slot for the incoming delay
  input  logic [SLOT_W-1:0]  add_dmod,   // incoming delay mod slots
  output twrt_cmd_t          cmd_out,
  output twrt_rel_t          rel
);

  logic                    valid_r, valid_nxt;
  logic [ID_W-1:0]         key_r, key_nxt;
  logic [SLOT_W-1:0]       dslot_r, dslot_nxt;  // delay mod slots
  logic                    canc_r, canc_nxt;
  logic [WHEEL_SLOTS-1:0]  mask_r, mask_nxt;
  twrt_cmd_t               cmd_r, cmd_nxt;
  twrt_rel_t               rel_nxt, rel_r;
  logic                    match;
  logic [SLOT_W:0]         rs_sum;
  logic [SLOT_W-1:0]       rs;
  logic [WHEEL_SLOTS-1:0]  cleared;

  assign match = valid_r && (key_r == cmd_in.id);

  // Refresh slot: cur + stored delay, one compare and subtract.
  always_comb begin
    rs_sum = {1'b0, cur_slot} + {1'b0, dslot_r};
    if (rs_sum >= (SLOT_W+1)'(WHEEL_SLOTS)) begin
      rs_sum = rs_sum - (SLOT_W+1)'(WHEEL_SLOTS);
    end
    rs = rs_sum[SLOT_W-1:0];
  end

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    dslot_nxt = dslot_r;
    canc_nxt  = canc_r;
    mask_nxt  = mask_r;
    cmd_nxt   = cmd_in;
    rel_nxt   = '0;
    cleared   = mask_r & ~(WHEEL_SLOTS'(1) << cur_slot);
    if (cmd_in.vld) begin
      unique case (cmd_in.act)
        ACT_ADD: begin
          // The first pass looks for the id; the second claims a free cell.
          if (cmd_in.is_first) begin
            if (!cmd_in.hit && match) begin
              cmd_nxt.hit = 1'b1;
              dslot_nxt   = add_dmod;
              canc_nxt    = 1'b0;
              mask_nxt    = mask_r | (WHEEL_SLOTS'(1) << add_slot);
            end
          end else if (!cmd_in.hit && !cmd_in.freed && !valid_r) begin
            cmd_nxt.freed = 1'b1;
            valid_nxt     = 1'b1;
            key_nxt       = cmd_in.id;
            dslot_nxt     = add_dmod;
            canc_nxt      = 1'b0;
            mask_nxt      = WHEEL_SLOTS'(1) << add_slot;
          end
        end
        ACT_REFRESH: begin
          if (cmd_in.is_first && !cmd_in.hit && match) begin
            cmd_nxt.hit = 1'b1;
            mask_nxt    = mask_r | (WHEEL_SLOTS'(1) << rs);
          end
        end
        ACT_CANCEL: begin
          if (cmd_in.is_first && !cmd_in.hit && match) begin
            cmd_nxt.hit = 1'b1;
            canc_nxt    = 1'b1;
          end
        end
        ACT_TICK: begin
          if (cmd_in.is_first && valid_r) begin
            mask_nxt = cleared;
            if (cleared == '0) begin
              valid_nxt        = 1'b0;
              rel_nxt.rel      = 1'b1;
              rel_nxt.canceled = canc_r;
              rel_nxt.id       = key_r;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cmd_r   <= '0;
      rel_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      cmd_r   <= cmd_nxt;
      rel_r   <= rel_nxt;
    end
    key_r   <= key_nxt;
    dslot_r <= dslot_nxt;
    canc_r  <= canc_nxt;
    mask_r  <= mask_nxt;
  end

  assign cmd_out = cmd_r;
  assign rel     = rel_r;

endmodule

FILE: hdl/timing_wheel_refresh_timers.sv
// ----------------------------------------------------------------------------
// timing_wheel_refresh_timers: hashed timing wheel with timer table
// A chain of timer cells; each command walks the chain one cell per cycle.
// ----------------------------------------------------------------------------
// channel | dir | ports                                   | accepted when
// in      | in  | in_action, in_timer_id, in_delay_ticks  | in_valid & in_ready
// out     | out | out_status, out_result_id, out_last     | out_valid & out_ready
//
// One item at a time. An accepted item passes through a prep state that
// reduces its delay modulo the slot count, then walks the chain; its result
// is taken from the chain's tail. An add whose id is not held makes a second
// pass to claim a free entry. A tick that releases timers queues them, in
// entry order, in a MAX_TIMERS deep buffer; releases leave one a cycle while
// out is ready, and out stalls hold the result. in_ready returns once the
// final result is taken and the state is back in idle.
// Reset clears all entries and the slot pointer at once.
// ----------------------------------------------------------------------------
module timing_wheel_refresh_timers
  import twrt_pkg::*;
#(
  parameter int WHEEL_SLOTS = 60,
  parameter int MAX_TIMERS  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_action,
  input  logic [ID_W-1:0]    in_timer_id,
  input  logic [DELAY_W-1:0] in_delay_ticks,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status,
  output logic [ID_W-1:0]    out_result_id,
  output logic               out_last
);

  localparam int SLOT_W = (WHEEL_SLOTS > 1) ? $clog2(WHEEL_SLOTS) : 1;
  localparam int TW     = $clog2(MAX_TIMERS + 1);
  localparam int IW     = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  // delay mod slots by reciprocal multiplication, exact for 16-bit delays
  localparam int RSH    = 22;
  localparam int PW     = DELAY_W + RSH;
  localparam int RECIP  = ((1 << RSH) + WHEEL_SLOTS - 1) / WHEEL_SLOTS;

  typedef enum logic [1:0] {S_IDLE, S_PREP, S_RUN, S_DRAIN} state_t;

  state_t              state_r, state_nxt;
  logic [SLOT_W-1:0]   cur_r, cur_nxt;
  logic [SLOT_W-1:0]   add_slot_r;
  logic [SLOT_W-1:0]   dmod_r;
  twrt_cmd_t           hold_r;
  logic [DELAY_W-1:0]  quo_r;
  twrt_cmd_t           head_r, head_nxt;
  twrt_cmd_t           chain [MAX_TIMERS+1];
  twrt_rel_t           rels  [MAX_TIMERS];
  // release queue: shift register of pending results
  twrt_rel_t           q_r [MAX_TIMERS];
  logic [TW-1:0]       qn_r;
  logic                res_v_r;
  logic [2:0]          res_st_r;
  logic [ID_W-1:0]     res_id_r;
  logic [PW-1:0]       prod;
  logic [DELAY_W-1:0]  rem;
  logic [SLOT_W-1:0]   dmod;
  logic [SLOT_W:0]     as_sum;
  logic [SLOT_W-1:0]   cur_adv;
  twrt_cmd_t           tail;

  assign chain[0] = head_r;
  assign tail     = chain[MAX_TIMERS];

  genvar g;
  generate
    for (g = 0; g < MAX_TIMERS; g++) begin : g_cell
      twrt_cell #(.WHEEL_SLOTS(WHEEL_SLOTS), .SLOT_W(SLOT_W)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .cur_slot (cur_r),
        .cmd_in   (chain[g]),
        .add_slot (add_slot_r),
        .add_dmod (dmod_r),
        .cmd_out  (chain[g+1]),
        .rel      (rels[g])
      );
    end
  endgenerate

  assign cur_adv = (cur_r == SLOT_W'(WHEEL_SLOTS - 1)) ? '0 : cur_r + 1'b1;

  // quotient taken at acceptance, remainder and add slot in the next cycle
  assign prod = PW'(in_delay_ticks) * PW'(RECIP);
  assign rem  = hold_r.delay - DELAY_W'(quo_r * DELAY_W'(WHEEL_SLOTS));
  assign dmod = rem[SLOT_W-1:0];

  always_comb begin
    as_sum = {1'b0, cur_r} + {1'b0, dmod};
    if (as_sum >= (SLOT_W+1)'(WHEEL_SLOTS)) begin
      as_sum = as_sum - (SLOT_W+1)'(WHEEL_SLOTS);
    end
  end

  assign in_ready = (state_r == S_IDLE) && !res_v_r;

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    head_nxt  = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          if (in_action == ACT_TICK) begin
            cur_nxt = cur_adv;
          end
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        head_nxt  = hold_r;
        state_nxt = S_RUN;
      end
      S_RUN: begin
        // relaunch add for the claim pass when lookup missed
        if (tail.vld && tail.act == ACT_ADD && tail.is_first && !tail.hit) begin
          head_nxt          = tail;
          head_nxt.is_first = 1'b0;
        end else if (tail.vld) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!res_v_r && qn_r == '0) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // result register and release queue
  integer k;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cur_r   <= '0;
      head_r  <= '0;
      qn_r    <= '0;
      res_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      head_r  <= head_nxt;
      if (state_r == S_IDLE && in_valid && in_ready) begin
        hold_r <= '{vld: 1'b1, act: in_action, id: in_timer_id,
                    delay: in_delay_ticks, hit: 1'b0, freed: 1'b0,
                    is_first: 1'b1};
        quo_r  <= prod[PW-1:RSH];
      end
      if (state_r == S_PREP) begin
        add_slot_r <= as_sum[SLOT_W-1:0];
        dmod_r     <= dmod;
      end
      // collect releases in entry order as the tick passes each cell
      for (k = 0; k < MAX_TIMERS; k++) begin
        if (rels[k].rel) begin
          q_r[qn_r[IW-1:0]] <= rels[k];
          qn_r              <= qn_r + 1'b1;
        end
      end
      if (res_v_r && out_ready) begin
        res_v_r <= 1'b0;
      end
      if (state_r == S_RUN && tail.vld &&
          !(tail.act == ACT_ADD && tail.is_first && !tail.hit)) begin
        if (tail.act != ACT_TICK) begin
          res_v_r  <= 1'b1;
          res_id_r <= tail.id;
          if (tail.act == ACT_ADD) begin
            res_st_r <= (tail.hit || tail.freed) ? ST_OK : ST_FULL;
          end else begin
            res_st_r <= tail.hit ? ST_OK : ST_NOT_FOUND;
          end
        end else if (qn_r == '0 && !rels[MAX_TIMERS-1].rel) begin
          res_v_r  <= 1'b1;
          res_id_r <= '0;
          res_st_r <= ST_OK;
        end
      end
      // drain queue front into the output register
      if (state_r == S_DRAIN && (!res_v_r || out_ready) && qn_r != '0) begin
        res_v_r  <= 1'b1;
        res_id_r <= q_r[0].id;
        res_st_r <= q_r[0].canceled ? ST_CANCELED : ST_FIRED;
        for (k = 0; k < MAX_TIMERS - 1; k++) begin
          q_r[k] <= q_r[k+1];
        end
        qn_r <= qn_r - 1'b1;
      end
    end
  end

  assign out_valid     = res_v_r;
  assign out_status    = res_st_r;
  assign out_result_id = res_id_r;
  assign out_last      = !(state_r == S_DRAIN && qn_r != '0);

  // An accepted item starts a pass, a non-final result is never shown in idle, and idle leaves no release queued.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_PREP))
    else $error("accepted item did not start a chain pass");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r != S_IDLE) || out_last)
    else $error("non-final result outside a tick");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (qn_r == '0))
    else $error("releases left queued while idle");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: timing wheel timer table testbench
// Drives add, refresh, cancel and tick items through the valid/ready input,
// predicts every release and acknowledgement, and checks each result item in
// order. A directed table opens the run, then random traffic, mostly on a small id pool.
// ----------------------------------------------------------------------------
module tb_top;
  import twrt_pkg::*;

  localparam int SLOTS   = 60;
  localparam int TIMERS  = 16;
  localparam int MAXREL  = 16;
  localparam int WDOG    = 20000;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] id;
    logic        last;
  } wheel_res_t;

  typedef struct {
    logic [1:0]  act;
    logic [31:0] id;
    logic [15:0] delay;
    logic        chk;     // expected result typed in
    logic [2:0]  st;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_action = '0;
  logic [31:0] in_timer_id = '0;
  logic [15:0] in_delay_ticks = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] out_status;
  logic [31:0] out_result_id;
  logic out_last;

  timing_wheel_refresh_timers dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state
  int unsigned slot_ptr;
  bit          tv[TIMERS];
  logic [31:0] tkey[TIMERS];
  logic [15:0] tdelay[TIMERS];
  bit          tcanc[TIMERS];
  logic [63:0] tmask[TIMERS];

  wheel_res_t pending_results[$];
  int mismatches = 0;
  int in_idle_pct = 0, out_idle_pct = 0;
  int stall_cnt = 0;
  bit timed_out = 0;

  function automatic void put_exp(wheel_res_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic int find_timer(logic [31:0] key);
    for (int i = 0; i < TIMERS; i++)
      if (tv[i] && tkey[i] == key) return i;
    return -1;
  endfunction

  function automatic logic [63:0] slot_mask(logic [15:0] d);
    int unsigned s;
    s = (slot_ptr + d % SLOTS) % SLOTS;
    return 64'd1 << s;
  endfunction

  function automatic void predict_wheel(logic [1:0] act, logic [31:0] id, logic [15:0] d);
    int e, n;
    wheel_res_t r;
    if (act == ACT_ADD) begin
      e = find_timer(id);
      if (e < 0) begin
        for (int i = 0; i < TIMERS; i++)
          if (!tv[i]) begin e = i; break; end
        if (e < 0) begin
          put_exp('{ST_FULL, id, 1'b1});
          return;
        end
        tv[e] = 1; tkey[e] = id; tmask[e] = '0;
      end
      tdelay[e] = d; tcanc[e] = 0;
      tmask[e] |= slot_mask(d);
      put_exp('{ST_OK, id, 1'b1});
    end else if (act == ACT_REFRESH || act == ACT_CANCEL) begin
      e = find_timer(id);
      if (e < 0) begin
        put_exp('{ST_NOT_FOUND, id, 1'b1});
        return;
      end
      if (act == ACT_REFRESH) tmask[e] |= slot_mask(tdelay[e]);
      else tcanc[e] = 1;
      put_exp('{ST_OK, id, 1'b1});
    end else begin
      slot_ptr = (slot_ptr + 1) % SLOTS;
      n = 0;
      for (int i = 0; i < TIMERS; i++) begin
        if (!tv[i]) continue;
        tmask[i][slot_ptr] = 1'b0;
        if (tmask[i] == '0 && n < MAXREL) begin
          r = '{tcanc[i] ? ST_CANCELED : ST_FIRED, tkey[i], 1'b0};
          put_exp(r);
          tv[i] = 0;
          n++;
        end
      end
      if (n == 0) put_exp('{ST_OK, 32'd0, 1'b1});
      else pending_results[$].last = 1'b1;
    end
  endfunction

  task automatic send_item(logic [1:0] act, logic [31:0] id, logic [15:0] d);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1; in_action <= act; in_timer_id <= id; in_delay_ticks <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_wheel(act, id, d);
  endtask

  // receiver and checker
  always @(posedge clk) begin
    wheel_res_t exp_r;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result item: status %0d id %h last %0d",
                     out_status, out_result_id, out_last);
        end else begin
          exp_r = pending_results.pop_front();
          if (exp_r.status !== out_status || exp_r.id !== out_result_id ||
              exp_r.last !== out_last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp status %0d id %h last %0d, got %0d %h %0d",
                       exp_r.status, exp_r.id, exp_r.last,
                       out_status, out_result_id, out_last);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= out_idle_pct);
      // watchdog on cycles without any accepted item
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cnt <= 0;
      else if (in_valid || pending_results.size() != 0) stall_cnt <= stall_cnt + 1;
    end
  end

  always @(posedge clk) begin
    if (stall_cnt >= WDOG && !timed_out) begin
      timed_out = 1;
      $display("Some tests failed");
      $finish;
    end
  end

  dir_row_t dir_tab[$];

  function automatic void add_row(logic [1:0] a, logic [31:0] id, logic [15:0] d,
                                  logic chk, logic [2:0] st);
    dir_row_t row;
    row = '{a, id, d, chk, st};
    dir_tab.insert(dir_tab.size(), row);
  endfunction

  function automatic logic [31:0] pick_id(int pool);
    return 32'hA5A50000 + $urandom_range(pool - 1);
  endfunction

  initial begin
    int r, k, phase;
    logic [1:0] a;
    slot_ptr = 0;
    for (int i = 0; i < TIMERS; i++) begin
      tv[i] = 0; tkey[i] = '0; tdelay[i] = '0; tcanc[i] = 0; tmask[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    add_row(ACT_TICK,    32'h0,          16'h0,    1, ST_OK);
    add_row(ACT_REFRESH, 32'hFFFFFFFF,   16'hFFFF, 1, ST_NOT_FOUND);
    add_row(ACT_CANCEL,  32'h0,          16'h0,    1, ST_NOT_FOUND);
    add_row(ACT_ADD,     32'hFFFFFFFF,   16'hFFFF, 1, ST_OK);
    add_row(ACT_ADD,     32'h0,          16'h0,    1, ST_OK);
    add_row(ACT_ADD,     32'h1,          16'd1,    1, ST_OK);
    add_row(ACT_CANCEL,  32'h1,          16'd0,    1, ST_OK);
    add_row(ACT_TICK,    32'h0,          16'h0,    0, ST_OK);
    add_row(ACT_REFRESH, 32'h1,          16'h0,    1, ST_NOT_FOUND);
    add_row(ACT_ADD,     32'h2,          16'd2,    1, ST_OK);
    add_row(ACT_REFRESH, 32'h2,          16'd0,    1, ST_OK);
    add_row(ACT_ADD,     32'h2,          16'd3,    1, ST_OK);
    add_row(ACT_CANCEL,  32'h2,          16'd0,    1, ST_OK);
    add_row(ACT_ADD,     32'h2,          16'd5,    1, ST_OK);
    add_row(ACT_TICK,    32'h0,          16'h0,    0, ST_OK);
    add_row(ACT_TICK,    32'h0,          16'h0,    0, ST_OK);
    for (int i = 0; i < 14; i++)
      add_row(ACT_ADD, 32'h100 + i, 16'd1, 0, ST_OK);
    add_row(ACT_ADD,     32'h5555AAAA,   16'd7,    1, ST_FULL);
    add_row(ACT_TICK,    32'h0,          16'h0,    0, ST_OK);

    out_idle_pct = 30;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].chk) begin
        // typed expectation for the single-result rows
        if (dir_tab[i].st == ST_FULL && find_timer(dir_tab[i].id) >= 0)
          $display("directed row %0d out of step", i);
      end
      send_item(dir_tab[i].act, dir_tab[i].id, dir_tab[i].delay);
      if (dir_tab[i].chk && pending_results[$].status !== dir_tab[i].st) begin
        mismatches++;
        if (mismatches <= 10)
          $display("directed row %0d: status %0d, table says %0d",
                   i, pending_results[$].status, dir_tab[i].st);
      end
    end

    // random part in three idling phases
    for (phase = 0; phase < 3; phase++) begin
      in_idle_pct  = (phase == 0) ? 26 : (phase == 1) ? 61 : 0;
      out_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 26 : 0;
      for (k = 0; k < 43; k++) begin
        r = $urandom_range(99);
        if (r < 10) begin
          send_item(2'($urandom_range(3)), $urandom, 16'($urandom));
        end else begin
          a = (r < 40) ? ACT_ADD : (r < 55) ? ACT_REFRESH : (r < 65) ? ACT_CANCEL
                                                            : ACT_TICK;
          send_item(a, pick_id(24),
                    ($urandom_range(3) == 0) ? 16'($urandom)
                                             : 16'($urandom_range(6)));
        end
      end
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (4 * TIMERS + 20) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
